// ===== design/audio_frame_descriptors_assert.svh =====
// Assertion macros for the frame descriptor back end.
// Expects clk and rst_n in the scope of use.
`ifndef AUDIO_FRAME_DESCRIPTORS_ASSERT_SVH
`define AUDIO_FRAME_DESCRIPTORS_ASSERT_SVH

// property that must hold at every edge out of reset
`define AFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define AFD_NEVER(lbl, cond, msg) `AFD_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/afd_pkg.sv =====
// Package for the audio frame descriptor block: defaults, register codes,
// configuration struct and fixed scale constants. No dependencies.
package afd_pkg;

    localparam int BANDS_DEF      = 16;
    localparam int RING_DEPTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    // configuration register indexes
    localparam logic [2:0] REG_ALPHA  = 3'd0;
    localparam logic [2:0] REG_FLOOR  = 3'd1;
    localparam logic [2:0] REG_SPAN   = 3'd2;
    localparam logic [2:0] REG_WINDOW = 3'd3;
    localparam logic [2:0] REG_RATE   = 3'd4;

    // reset values
    localparam logic [15:0]        ALPHA_RST  = 16'd655;
    localparam logic signed [12:0] FLOOR_RST  = -13'sd3072;
    localparam logic [12:0]        SPAN_RST   = 13'd3072;
    localparam logic [15:0]        WINDOW_RST = 16'd4000;
    localparam logic [9:0]         RATE_RST   = 10'd8;

    // descriptor scale: 255, and 255 * 1000 ms per second
    localparam int ENG_SCALE  = 255;
    localparam int DENS_SCALE = 255000;

    typedef struct packed {
        logic [15:0]        alpha;
        logic signed [12:0] floor_q;
        logic [12:0]        span;
        logic [15:0]        window;
        logic [9:0]         rate;
    } afd_cfg_t;

endpackage

// ===== design/audio_frame_descriptors.sv =====
// Top level of the audio frame descriptor block: configuration registers,
// front end, request queue and back end. Depends on afd_pkg and all afd_ modules.
//
// Band items are taken one per cycle while full is low. Each last band closes a
// frame and queues one request for the back end. For each request the back end
// runs the centroid division, log2 normalization, the squaring loop, the energy
// division, the ring write, the scan of the event ring and the density division;
// the up to three divisions share one bit-serial divider (DIV_W is 33 at 16
// bands). The finished result then waits for pop. A two-request queue lets the
// next frame's bands stream in while the back end works; full rises only when
// that queue is full. The ring is tracked by a fill count, so there is no
// clearing pass after reset.
module audio_frame_descriptors
    import afd_pkg::*;
#(
    parameter int BANDS      = BANDS_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] band_magnitude,
    input  logic        last_band,
    input  logic [15:0] frame_rms,
    input  logic        event_seen,
    input  logic [31:0] time_ms,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  centroid,
    output logic [7:0]  energy,
    output logic [7:0]  density,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int CNT_W  = $clog2(BANDS + 1);
    localparam int MSUM_W = 16 + CNT_W;
    localparam int WSUM_W = MSUM_W + $clog2(BANDS);
    localparam int REC_W  = MSUM_W + WSUM_W + 49;

    afd_cfg_t         cfg_reg;
    logic             accept;
    logic             q_push, q_full, q_empty, q_pop;
    logic [REC_W-1:0] q_wdata, q_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha   <= ALPHA_RST;
            cfg_reg.floor_q <= FLOOR_RST;
            cfg_reg.span    <= SPAN_RST;
            cfg_reg.window  <= WINDOW_RST;
            cfg_reg.rate    <= RATE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ALPHA:  cfg_reg.alpha   <= cfg_data;
                REG_FLOOR:  cfg_reg.floor_q <= $signed(cfg_data[12:0]);
                REG_SPAN:   cfg_reg.span    <= cfg_data[12:0];
                REG_WINDOW: cfg_reg.window  <= cfg_data;
                REG_RATE:   cfg_reg.rate    <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    afd_front #(
        .BANDS (BANDS),
        .REC_W (REC_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .band_magnitude (band_magnitude),
        .last_band      (last_band),
        .frame_rms      (frame_rms),
        .event_seen     (event_seen),
        .time_ms        (time_ms),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    afd_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    afd_back #(
        .BANDS      (BANDS),
        .RING_DEPTH (RING_DEPTH),
        .REC_W      (REC_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .centroid (centroid),
        .energy   (energy),
        .density  (density)
    );

endmodule

// ===== design/afd_queue.sv =====
// Small FIFO of frame requests between the band front end and the back end.
// Depends on afd_pkg for its depth.
module afd_queue
    import afd_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/afd_front.sv =====
// Front end: accumulates band magnitudes and emits one frame request on the
// last band. Depends on afd_pkg.
module afd_front
    import afd_pkg::*;
#(
    parameter int BANDS = BANDS_DEF,
    parameter int REC_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [15:0]      band_magnitude,
    input  logic             last_band,
    input  logic [15:0]      frame_rms,
    input  logic             event_seen,
    input  logic [31:0]      time_ms,
    output logic             q_push,
    output logic [REC_W-1:0] q_data
);
    localparam int CNT_W  = $clog2(BANDS + 1);
    localparam int MSUM_W = 16 + CNT_W;
    localparam int WSUM_W = MSUM_W + $clog2(BANDS);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MSUM_W-1:0] msum_reg, msum_next, msum_sum;
    logic [WSUM_W-1:0] wsum_reg, wsum_next, wsum_sum;
    logic              in_frame;

    // extra bands past BANDS are dropped
    assign in_frame = (cnt_reg < CNT_W'(BANDS));
    assign msum_sum = msum_reg + (in_frame ? MSUM_W'(band_magnitude) : '0);
    assign wsum_sum = wsum_reg +
                      (in_frame ? WSUM_W'(band_magnitude) * WSUM_W'(cnt_reg) : '0);

    assign q_push = accept && last_band;
    assign q_data = {msum_sum, wsum_sum, frame_rms, event_seen, time_ms};

    always_comb
    begin
        cnt_next  = cnt_reg;
        msum_next = msum_reg;
        wsum_next = wsum_reg;
        if (accept)
        begin
            if (last_band)
            begin
                cnt_next  = '0;
                msum_next = '0;
                wsum_next = '0;
            end
            else
            begin
                cnt_next  = in_frame ? cnt_reg + 1'b1 : cnt_reg;
                msum_next = msum_sum;
                wsum_next = wsum_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            msum_reg <= '0;
            wsum_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            msum_reg <= msum_next;
            wsum_reg <= wsum_next;
        end
    end

endmodule

// ===== design/afd_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient saturated to 255.
// Depends on afd_pkg.
module afd_div
    import afd_pkg::*;
#(
    parameter int DIV_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic             done,
    output logic [7:0]       quot
);
    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  q_reg;
    logic [DIV_W-1:0]  d_reg;
    logic [DIV_W:0]    rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [DIV_W:0]    rem_shift;
    logic              fits;

    assign rem_shift = {rem_reg[DIV_W-1:0], q_reg[DIV_W-1]};
    assign fits      = (rem_shift >= {1'b0, d_reg});
    assign done      = busy_reg && (step_reg == '0);
    assign quot      = (q_reg > DIV_W'(255)) ? 8'd255 : q_reg[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(DIV_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            d_reg   <= den;
            rem_reg <= '0;
        end
        else if (busy_reg && (step_reg != '0))
        begin
            rem_reg <= fits ? rem_shift - {1'b0, d_reg} : rem_shift;
            q_reg   <= {q_reg[DIV_W-2:0], fits};
        end
    end

endmodule

// ===== design/afd_back.sv =====
// Back end: per-frame sequencer for centroid, energy envelope and log2,
// event ring and density. Depends on afd_pkg, afd_div and the assert header.
`include "audio_frame_descriptors_assert.svh"
module afd_back
    import afd_pkg::*;
#(
    parameter int BANDS      = BANDS_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int REC_W      = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  afd_cfg_t         cfg,
    input  logic             q_empty,
    input  logic [REC_W-1:0] q_data,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       centroid,
    output logic [7:0]       energy,
    output logic [7:0]       density
);
    localparam int CNT_W   = $clog2(BANDS + 1);
    localparam int MSUM_W  = 16 + CNT_W;
    localparam int WSUM_W  = MSUM_W + $clog2(BANDS);
    localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int STO_W   = $clog2(RING_DEPTH + 1);
    localparam int CNUM_W  = WSUM_W + 8;
    localparam int DNUM_W  = 18 + STO_W;
    localparam int DIV_A   = (CNUM_W > DNUM_W) ? CNUM_W : DNUM_W;
    localparam int DIV_W   = (DIV_A > 26) ? DIV_A : 26;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_ENV_MUL  = 5'd1;
    localparam logic [4:0] S_ENV_SUM  = 5'd2;
    localparam logic [4:0] S_CEN      = 5'd3;
    localparam logic [4:0] S_CEN_WAIT = 5'd4;
    localparam logic [4:0] S_NORM     = 5'd5;
    localparam logic [4:0] S_SQ_MUL   = 5'd6;
    localparam logic [4:0] S_SQ_ADJ   = 5'd7;
    localparam logic [4:0] S_ENG      = 5'd8;
    localparam logic [4:0] S_ENG_WAIT = 5'd9;
    localparam logic [4:0] S_RING_WR  = 5'd10;
    localparam logic [4:0] S_SCAN_RD  = 5'd11;
    localparam logic [4:0] S_SCAN_CMP = 5'd12;
    localparam logic [4:0] S_DEN_MUL  = 5'd13;
    localparam logic [4:0] S_DEN      = 5'd14;
    localparam logic [4:0] S_DEN_WAIT = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    logic [4:0]        state_reg;

    // frame request fields
    logic [MSUM_W-1:0] msum_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [15:0]       rms_reg;
    logic              evt_reg;
    logic [31:0]       now_reg;
    logic [31:0]       wstart_reg;
    logic [15:0]       wms_reg;
    logic [MSUM_W-1:0] q_msum;
    logic [WSUM_W-1:0] q_wsum;
    logic [15:0]       q_rms;
    logic              q_evt;
    logic [31:0]       q_now;
    logic [15:0]       win;

    // envelope and log
    logic [23:0]       env_reg;
    logic [40:0]       pa_reg, pb_reg, env_sum;
    logic [24:0]       env_shr;
    logic [23:0]       env_next;
    logic [16:0]       alpha_inv;
    logic [23:0]       x_reg;
    logic [47:0]       sq_reg;
    logic [24:0]       sq_shr;
    logic [4:0]        p_reg;
    logic [7:0]        frac_reg;
    logic [2:0]        iter_reg;
    logic signed [13:0] log_val;
    logic signed [14:0] diff;

    // centroid operands
    logic [DIV_W-1:0]  cnum_reg, cden_reg;

    // event ring
    logic [31:0]       event_times [RING_DEPTH];
    logic [31:0]       rd_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [STO_W-1:0]  stored_reg;
    logic [STO_W-1:0]  scan_reg;
    logic [STO_W-1:0]  n_reg;
    logic [25:0]       wprod_reg;
    logic              ring_we;

    // divider
    logic              div_start;
    logic [DIV_W-1:0]  div_num, div_den;
    logic              div_done;
    logic [7:0]        div_q;

    // results
    logic [7:0]        cen_reg, eng_reg, dens_reg;
    logic              res_valid_reg;
    logic [7:0]        cen_out_reg, eng_out_reg, dens_out_reg;
    logic              res_load;

    assign {q_msum, q_wsum, q_rms, q_evt, q_now} = q_data;
    assign win = (cfg.window == '0) ? 16'd1 : cfg.window;

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    assign alpha_inv = 17'h10000 - {1'b0, cfg.alpha};
    assign env_sum   = pa_reg + pb_reg + 41'd32768;
    assign env_shr   = env_sum[40:16];
    assign env_next  = env_shr[24] ? 24'hFFFFFF : env_shr[23:0];
    assign sq_shr    = sq_reg[47:23];
    assign log_val   = $signed({6'(p_reg) - 6'd24, frac_reg});
    assign diff      = 15'(log_val) - 15'(cfg.floor_q);

    assign ring_we  = (state_reg == S_RING_WR) && evt_reg;
    assign res_load = (state_reg == S_DONE) && (!res_valid_reg || pop);

    assign empty    = !res_valid_reg;
    assign centroid = cen_out_reg;
    assign energy   = eng_out_reg;
    assign density  = dens_out_reg;

    // shared divider requests
    always_comb
    begin
        div_start = 1'b0;
        div_num   = cnum_reg;
        div_den   = cden_reg;
        unique case (state_reg)
            S_CEN:
            begin
                div_start = (msum_reg != '0);
            end
            S_ENG:
            begin
                div_start = (diff > 15'sd0) && (cfg.span != '0);
                div_num   = DIV_W'(diff[13:0]) * DIV_W'(ENG_SCALE);
                div_den   = DIV_W'(cfg.span);
            end
            S_DEN:
            begin
                div_start = (n_reg != '0) && (cfg.rate != '0);
                div_num   = DIV_W'(n_reg) * DIV_W'(DENS_SCALE);
                div_den   = DIV_W'(wprod_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    afd_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            env_reg       <= '0;
            head_reg      <= '0;
            stored_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_ENV_MUL;
                    end
                end
                S_ENV_MUL:
                begin
                    state_reg <= S_ENV_SUM;
                end
                S_ENV_SUM:
                begin
                    env_reg   <= env_next;
                    state_reg <= S_CEN;
                end
                S_CEN:
                begin
                    state_reg <= (msum_reg != '0) ? S_CEN_WAIT : S_NORM;
                end
                S_CEN_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (env_reg == '0)
                    begin
                        state_reg <= S_RING_WR;
                    end
                    else if (x_reg[23] || (p_reg == '0))
                    begin
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_SQ_MUL:
                begin
                    state_reg <= S_SQ_ADJ;
                end
                S_SQ_ADJ:
                begin
                    state_reg <= (iter_reg == 3'd7) ? S_ENG : S_SQ_MUL;
                end
                S_ENG:
                begin
                    state_reg <= div_start ? S_ENG_WAIT : S_RING_WR;
                end
                S_ENG_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_RING_WR;
                    end
                end
                S_RING_WR:
                begin
                    if (evt_reg)
                    begin
                        head_reg <= (head_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                         : head_reg + 1'b1;
                        if (stored_reg < STO_W'(RING_DEPTH))
                        begin
                            stored_reg <= stored_reg + 1'b1;
                        end
                    end
                    state_reg <= S_SCAN_RD;
                end
                S_SCAN_RD:
                begin
                    state_reg <= (scan_reg < stored_reg) ? S_SCAN_CMP : S_DEN_MUL;
                end
                S_SCAN_CMP:
                begin
                    state_reg <= S_SCAN_RD;
                end
                S_DEN_MUL:
                begin
                    state_reg <= S_DEN;
                end
                S_DEN:
                begin
                    state_reg <= div_start ? S_DEN_WAIT : S_DONE;
                end
                S_DEN_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                msum_reg   <= q_msum;
                wsum_reg   <= q_wsum;
                rms_reg    <= q_rms;
                evt_reg    <= q_evt;
                now_reg    <= q_now;
                wstart_reg <= (q_now > 32'(win)) ? q_now - 32'(win) : '0;
                wms_reg    <= (q_now < 32'(win)) ? ((q_now == '0) ? 16'd1 : q_now[15:0])
                                                 : win;
            end
            S_ENV_MUL:
            begin
                pa_reg   <= 41'(env_reg) * 41'(alpha_inv);
                pb_reg   <= 41'({rms_reg, 8'd0}) * 41'(cfg.alpha);
                cnum_reg <= DIV_W'({wsum_reg, 8'd0}) - DIV_W'(wsum_reg);
                cden_reg <= DIV_W'(msum_reg) * DIV_W'(BANDS - 1);
            end
            S_ENV_SUM:
            begin
                x_reg <= env_next;
                p_reg <= 5'd23;
            end
            S_CEN:
            begin
                cen_reg <= '0;
            end
            S_CEN_WAIT:
            begin
                if (div_done)
                begin
                    cen_reg <= div_q;
                end
            end
            S_NORM:
            begin
                eng_reg  <= '0;
                frac_reg <= '0;
                iter_reg <= '0;
                if (!x_reg[23] && (p_reg != '0))
                begin
                    x_reg <= {x_reg[22:0], 1'b0};
                    p_reg <= p_reg - 1'b1;
                end
            end
            S_SQ_MUL:
            begin
                sq_reg <= 48'(x_reg) * 48'(x_reg);
            end
            S_SQ_ADJ:
            begin
                x_reg    <= sq_shr[24] ? sq_shr[24:1] : sq_shr[23:0];
                frac_reg <= {frac_reg[6:0], sq_shr[24]};
                iter_reg <= iter_reg + 1'b1;
            end
            S_ENG:
            begin
                eng_reg <= ((diff > 15'sd0) && (cfg.span == '0)) ? 8'd255 : 8'd0;
            end
            S_ENG_WAIT:
            begin
                if (div_done)
                begin
                    eng_reg <= div_q;
                end
            end
            S_RING_WR:
            begin
                scan_reg <= '0;
                n_reg    <= '0;
            end
            S_SCAN_CMP:
            begin
                if (rd_reg >= wstart_reg)
                begin
                    n_reg <= n_reg + 1'b1;
                end
                scan_reg <= scan_reg + 1'b1;
            end
            S_DEN_MUL:
            begin
                wprod_reg <= 26'(wms_reg) * 26'(cfg.rate);
            end
            S_DEN:
            begin
                dens_reg <= (n_reg != '0) ? 8'd255 : 8'd0;
            end
            S_DEN_WAIT:
            begin
                if (div_done)
                begin
                    dens_reg <= div_q;
                end
            end
            default:
            begin
            end
        endcase

        if (res_load)
        begin
            cen_out_reg  <= cen_reg;
            eng_out_reg  <= eng_reg;
            dens_out_reg <= dens_reg;
        end
    end

    // event time ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            event_times[head_reg] <= now_reg;
        end
        rd_reg <= event_times[scan_reg[IDX_W-1:0]];
    end

    `AFD_ASSERT(a_pop_only_idle, q_pop |-> (state_reg == S_IDLE), "request taken while busy")
    `AFD_ASSERT(a_result_held, (res_valid_reg && !pop) |=> (res_valid_reg && $stable(cen_out_reg) && $stable(eng_out_reg) && $stable(dens_out_reg)), "waiting result changed")
    `AFD_NEVER(a_ring_count, stored_reg > STO_W'(RING_DEPTH), "ring count over depth")
    `AFD_NEVER(a_div_restart, div_start && (state_reg == S_CEN_WAIT || state_reg == S_ENG_WAIT || state_reg == S_DEN_WAIT), "divider restarted while busy")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for audio_frame_descriptors: a directed table, then
// random frames under several register settings, checked against a predictor.
// Depends on afd_pkg and the audio_frame_descriptors RTL.
module tb_top;
    import afd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBANDS  = 16;
    localparam int NRING   = 32;
    localparam int SETTLE  = 300;
    localparam int N_ITEMS = 1450;

    typedef struct {
        logic [15:0] mag;
        logic        last;
        logic [15:0] rms;
        logic        ev;
        logic [31:0] tms;
    } band_req_t;

    typedef struct packed {
        logic [7:0] centroid;
        logic [7:0] energy;
        logic [7:0] density;
    } desc_t;

    typedef struct {
        band_req_t req;
        bit        typed;
        desc_t     want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] band_magnitude = '0;
    logic        last_band = 1'b0;
    logic [15:0] frame_rms = '0;
    logic        event_seen = 1'b0;
    logic [31:0] time_ms = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  centroid, energy, density;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = REG_ALPHA;
    logic [15:0] cfg_data = '0;

    // predictor state and register copies
    int unsigned        alpha_r = 655;
    int                 floor_r = -3072;
    int unsigned        span_r = 3072;
    int unsigned        window_r = 4000;
    int unsigned        rate_r = 8;
    longint unsigned    mag_acc, wsum_acc, env_acc;
    int unsigned        band_cnt, ring_head, ring_fill;
    logic [31:0]        event_ring [NRING];

    desc_t expected_desc [$];
    int    errors = 0;
    bit    drv_burst, mon_burst;

    audio_frame_descriptors u_dut (.*);

    always #5 clk = ~clk;

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [7:0] sat8(longint unsigned v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // floored log2 of env/2^24 in Q8.8
    function automatic int log2_env(longint unsigned e);
        int p;
        int frac;
        longint unsigned x;
        p = 23;
        frac = 0;
        while (p > 0 && e[p] == 1'b0)
            p--;
        x = e << (23 - p);
        for (int k = 0; k < 8; k++)
        begin
            x = (x * x) >> 23;
            frac = frac * 2;
            if (x >= (64'd1 << 24))
            begin
                x = x >> 1;
                frac++;
            end
        end
        return (p - 24) * 256 + frac;
    endfunction

    // band accumulation; on the last band, the frame descriptors
    function automatic bit frame_descriptors(band_req_t r, output desc_t d);
        longint unsigned e;
        int dlog;
        int unsigned win, wstart, wms, n;
        d = '0;
        if (band_cnt < NBANDS)
        begin
            mag_acc += r.mag;
            wsum_acc += longint'(r.mag) * band_cnt;
            band_cnt++;
        end
        if (!r.last)
            return 1'b0;
        d.centroid = (mag_acc == 0) ? 8'd0 : sat8((wsum_acc * 255) / (mag_acc * (NBANDS - 1)));
        mag_acc = 0;
        wsum_acc = 0;
        band_cnt = 0;
        // envelope and energy
        e = (env_acc * (65536 - alpha_r) + (longint'(r.rms) << 8) * alpha_r + 32768) >> 16;
        if (e > 64'hFFFFFF)
            e = 64'hFFFFFF;
        env_acc = e;
        if (env_acc == 0)
            d.energy = 8'd0;
        else
        begin
            dlog = log2_env(env_acc) - floor_r;
            if (dlog <= 0)
                d.energy = 8'd0;
            else if (span_r == 0)
                d.energy = 8'd255;
            else
                d.energy = sat8((longint'(dlog) * 255) / span_r);
        end
        // event ring and density
        if (r.ev)
        begin
            event_ring[ring_head] = r.tms;
            ring_head = (ring_head + 1) % NRING;
            if (ring_fill < NRING)
                ring_fill++;
        end
        win = (window_r == 0) ? 1 : window_r;
        wstart = (r.tms > win) ? r.tms - win : 0;
        n = 0;
        for (int i = 0; i < ring_fill; i++)
            if (event_ring[i] >= wstart)
                n++;
        wms = (r.tms < win) ? ((r.tms == 0) ? 1 : r.tms) : win;
        if (n == 0)
            d.density = 8'd0;
        else if (rate_r == 0)
            d.density = 8'd255;
        else
            d.density = sat8((longint'(n) * 255000) / (longint'(wms) * rate_r));
        return 1'b1;
    endfunction

    // register write, mirrored into the predictor
    task automatic write_reg(logic [2:0] idx, int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        case (idx)
            REG_ALPHA:  alpha_r = value[15:0];
            REG_FLOOR:  floor_r = $signed(value[12:0]);
            REG_SPAN:   span_r = value[12:0];
            REG_WINDOW: window_r = value[15:0];
            REG_RATE:   rate_r = value[9:0];
            default:    ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // one request through the input side; typed rows override the predictor
    task automatic send_band(band_req_t r, bit typed, desc_t want);
        int gap;
        desc_t d;
        gap = drv_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        band_magnitude <= r.mag;
        last_band <= r.last;
        frame_rms <= r.rms;
        event_seen <= r.ev;
        time_ms <= r.tms;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (frame_descriptors(r, d))
            expected_desc.push_back(typed ? want : d);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_desc.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // stimulus
    initial begin
        dir_row_t    dir_tab [$];
        band_req_t   r;
        int          sent, nb, phase;
        logic [31:0] tnow;
        desc_t       none;
        none = '0;
        for (int i = 0; i < NRING; i++)
            event_ring[i] = '0;
        mag_acc = 0;
        wsum_acc = 0;
        env_acc = 0;
        band_cnt = 0;
        ring_head = 0;
        ring_fill = 0;

        // silence right after reset: all descriptors zero
        dir_tab.push_back('{'{16'd0, 1'b1, 16'd0, 1'b0, 32'd0}, 1'b1, desc_t'(24'h0)});
        // full-scale frame with two extra bands that are ignored
        for (int i = 0; i < 18; i++)
            dir_tab.push_back('{'{16'hFFFF, i == 17, 16'hFFFF, 1'b1, 32'hFFFF_FFFF},
                                1'b0, none});
        // short frame, only band 0 loud; event at time zero
        dir_tab.push_back('{'{16'hFFFF, 1'b0, 16'h0, 1'b0, 32'h0}, 1'b0, none});
        dir_tab.push_back('{'{16'h0, 1'b1, 16'h8000, 1'b1, 32'h0}, 1'b0, none});
        // centroid at the top of the band, only the last band loud
        for (int i = 0; i < 16; i++)
            dir_tab.push_back('{'{(i == 15) ? 16'h0001 : 16'h0, i == 15, 16'hFFFF, 1'b1,
                                  32'd1500}, 1'b0, none});
        // event times earlier than stored ones still count
        dir_tab.push_back('{'{16'h1234, 1'b1, 16'h0001, 1'b1, 32'd10}, 1'b0, none});

        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_band(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

        sent = 0;
        tnow = 32'd0;
        for (phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase)
                0: begin
                    write_reg(REG_ALPHA, 1); write_reg(REG_FLOOR, -4096);
                    write_reg(REG_SPAN, 1); write_reg(REG_WINDOW, 1); write_reg(REG_RATE, 1);
                end
                1: begin
                    write_reg(REG_ALPHA, 65535); write_reg(REG_FLOOR, 0);
                    write_reg(REG_SPAN, 4096); write_reg(REG_WINDOW, 60000);
                    write_reg(REG_RATE, 1000);
                end
                5: begin
                    write_reg(REG_ALPHA, 655); write_reg(REG_FLOOR, -3072);
                    write_reg(REG_SPAN, 3072); write_reg(REG_WINDOW, 4000); write_reg(REG_RATE, 8);
                end
                default: begin
                    write_reg(REG_ALPHA, $urandom_range(1, 65535));
                    write_reg(REG_FLOOR, -$urandom_range(0, 4096));
                    write_reg(REG_SPAN, $urandom_range(1, 4096));
                    write_reg(REG_WINDOW, $urandom_range(1, 60000));
                    write_reg(REG_RATE, $urandom_range(1, 1000));
                end
            endcase
            // random frames; mostly full length, some short or overlong
            while (sent < (phase + 1) * N_ITEMS / 6)
            begin
                nb = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 18) : NBANDS;
                if ($urandom_range(0, 19) == 0)
                    tnow = $urandom();
                else if ($urandom_range(0, 29) == 0)
                    tnow = $urandom_range(0, 100);
                else
                    tnow = tnow + $urandom_range(0, 1500);
                for (int b = 0; b < nb; b++)
                begin
                    if (sent % 40 == 0)
                        drv_burst = ($urandom_range(0, 3) == 0);
                    r.mag = ($urandom_range(0, 7) == 0) ? 16'h0
                            : 16'($urandom() >> $urandom_range(16, 31));
                    r.last = (b == nb - 1);
                    r.rms = 16'($urandom() >> $urandom_range(16, 31));
                    r.ev = $urandom_range(0, 1);
                    r.tms = r.last ? tnow : $urandom();
                    send_band(r, 1'b0, none);
                    sent++;
                end
            end
        end

        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result side: random pop stalls, compare with the oldest expectation
    initial begin
        int    gap;
        int    got_n;
        desc_t want;
        got_n = 0;
        @(posedge rst_n);
        forever
        begin
            if (got_n % 30 == 0)
                mon_burst = ($urandom_range(0, 3) == 0);
            gap = mon_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            got_n++;
            if (expected_desc.size() == 0)
                report("unexpected result", centroid, -1);
            else
            begin
                want = expected_desc.pop_front();
                if (centroid !== want.centroid)
                    report("centroid", centroid, want.centroid);
                if (energy !== want.energy)
                    report("energy", energy, want.energy);
                if (density !== want.density)
                    report("density", density, want.density);
            end
        end
    end

endmodule

// ===== files.f =====
+incdir+design
design/afd_pkg.sv
design/afd_queue.sv
design/afd_front.sv
design/afd_div.sv
design/afd_back.sv
design/audio_frame_descriptors.sv
sim/tb_top.sv
